// File: hw/rtl/stg_pkg.sv
// stg_pkg: shared types, codes, microcode program and sine table function
// for the sine tone generator. No dependencies; used by sine_tone_generator_top.

package stg_pkg;

  localparam int unsigned TableBitsDefault   = 8;
  localparam int unsigned MaxChannelsDefault = 2;

  localparam int unsigned PhaseW  = 32;
  localparam int unsigned AmpW    = 15;
  localparam int unsigned ChanCntW = 2;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPhaseStep   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegToneAmp     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegChannelCount = 2'd2;

  // microcode program
  localparam int unsigned StepW = 3;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StepAccept = 3'd0;
  localparam step_t StepPhase  = 3'd1;
  localparam step_t StepLookup = 3'd2;
  localparam step_t StepScale  = 3'd3;
  localparam step_t StepEmit0  = 3'd4;
  localparam step_t StepEmit1  = 3'd5;
  localparam int unsigned ProgLen = 6;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_PHASE,
    OP_LOOKUP,
    OP_SCALE,
    OP_EMIT0,
    OP_EMIT1
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_WAIT_IN,
    C_EMIT_FIRST,
    C_EMIT_LAST
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode(input step_t step);
    ucode_t w;
    w = '{op: OP_ACCEPT, cond: C_WAIT_IN, target: StepAccept};
    case (step)
      StepAccept: w = '{op: OP_ACCEPT, cond: C_WAIT_IN,    target: StepAccept};
      StepPhase:  w = '{op: OP_PHASE,  cond: C_NEXT,       target: StepAccept};
      StepLookup: w = '{op: OP_LOOKUP, cond: C_NEXT,       target: StepAccept};
      StepScale:  w = '{op: OP_SCALE,  cond: C_NEXT,       target: StepAccept};
      StepEmit0:  w = '{op: OP_EMIT0,  cond: C_EMIT_FIRST, target: StepAccept};
      StepEmit1:  w = '{op: OP_EMIT1,  cond: C_EMIT_LAST,  target: StepAccept};
      default:    w = '{op: OP_ACCEPT, cond: C_WAIT_IN,    target: StepAccept};
    endcase
    return w;
  endfunction

  // sin(k*pi/2^(tbits+1)) in Q15, Taylor series in Q30, evaluated at elaboration
  function automatic logic [AmpW-1:0] sine_q15(input int unsigned k,
                                               input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = (64'(k) * 64'd1686629713) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    r = (sum + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[AmpW-1:0];
  endfunction

endpackage

// File: hw/rtl/sine_tone_generator_top.sv
// sine_tone_generator_top: microcoded sine tone generator, quarter-wave table
// lookup and amplitude scaling. Depends on stg_pkg.
//
// Usage: configure phase_step, tone_amp and channel_count through the write
// port (cfg_we_i, cfg_idx_i, cfg_data_i) while the block is idle. Each input
// transaction on s_axis is one sample tick; tuser carries restart, tdata the
// start index. For each tick the block returns one m_axis transaction per
// channel (one or two) with the same signed sample, the channel in tuser and
// tlast on the final channel of the tick.
// Sequence: a tick runs through a six-step microprogram held in a constant
// control table: accept, phase reload (32x32 multiply), table read, amplitude
// multiply with phase advance, then one emit step per channel. The sequencer
// moves one step per cycle except while it waits for a tick in the accept
// step or for the receiver in an emit step; the first sample is registered
// in the first emit step, and s_axis_tready_o is high only in the accept step.
// Reset clears the configuration to phase_step 0, tone_amp 0, one channel,
// zeroes the phase and marks the block not started, so the first tick
// reloads the phase from its start index. When the receiver stalls, the
// output register holds its transaction and the sequencer waits in the emit
// step; no result is dropped.

module sine_tone_generator_top #(
  parameter int unsigned TableBits   = stg_pkg::TableBitsDefault,
  parameter int unsigned MaxChannels = stg_pkg::MaxChannelsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [stg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [stg_pkg::CfgDataW-1:0]  cfg_data_i,
  // tick input
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,  // [31:0] start_index
  input  logic                          s_axis_tuser_i,  // [0] restart
  // sample output
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [stg_pkg::SampleW-1:0]   m_axis_tdata_o,  // [15:0] sample_out
  output logic                          m_axis_tuser_o,  // [0] channel_index
  output logic                          m_axis_tlast_o
);

  localparam int unsigned QtabN  = 1 << TableBits;
  localparam int unsigned AddrW  = TableBits + 1;

  // quarter-wave table, constant
  logic [stg_pkg::AmpW-1:0] qtab [QtabN+1];
  for (genvar k = 0; k <= QtabN; k++) begin : g_qtab
    assign qtab[k] = stg_pkg::sine_q15(k, TableBits);
  end

  // configuration registers
  logic [stg_pkg::PhaseW-1:0]   phase_step_q;
  logic [stg_pkg::AmpW-1:0]     tone_amp_q;
  logic [stg_pkg::ChanCntW-1:0] chan_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      tone_amp_q   <= '0;
      chan_cnt_q   <= stg_pkg::ChanCntW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stg_pkg::RegPhaseStep:    phase_step_q <= cfg_data_i[stg_pkg::PhaseW-1:0];
        stg_pkg::RegToneAmp:      tone_amp_q   <= cfg_data_i[stg_pkg::AmpW-1:0];
        stg_pkg::RegChannelCount: chan_cnt_q   <= cfg_data_i[stg_pkg::ChanCntW-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one channel, anything above the maximum as the maximum
  logic single_chan;
  assign single_chan = (MaxChannels < 2) || (chan_cnt_q < stg_pkg::ChanCntW'(2));

  // sequencer
  stg_pkg::step_t  step_q, step_d;
  stg_pkg::ucode_t cw;
  logic            in_acc;
  logic            out_free;

  assign cw              = stg_pkg::ucode(step_q);
  assign s_axis_tready_o = (cw.op == stg_pkg::OP_ACCEPT);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;

  always_comb begin
    step_d = step_q;
    case (cw.cond)
      stg_pkg::C_NEXT:       step_d = step_q + stg_pkg::step_t'(1);
      stg_pkg::C_WAIT_IN:    step_d = in_acc ? step_q + stg_pkg::step_t'(1) : step_q;
      stg_pkg::C_EMIT_FIRST: begin
        if (out_free) begin
          step_d = single_chan ? cw.target : step_q + stg_pkg::step_t'(1);
        end
      end
      stg_pkg::C_EMIT_LAST:  step_d = out_free ? cw.target : step_q;
      default:               step_d = stg_pkg::StepAccept;
    endcase
  end

  // datapath
  logic [stg_pkg::PhaseW-1:0] phase_q;
  logic                       started_q;
  logic                       reload_q;
  logic [31:0]                start_q;
  logic [stg_pkg::AmpW-1:0]   rom_q;
  logic                       neg_q;
  logic [stg_pkg::AmpW-1:0]   mag_q;
  logic [TableBits-1:0]       k_idx;
  logic [AddrW-1:0]           rom_addr;
  logic [2*stg_pkg::AmpW-1:0] prod;
  logic [stg_pkg::SampleW-1:0] sample_val;

  assign k_idx    = phase_q[29 -: TableBits];
  assign rom_addr = phase_q[30] ? AddrW'(QtabN) - AddrW'(k_idx) : AddrW'(k_idx);
  assign prod     = tone_amp_q * rom_q;
  assign sample_val = neg_q ? stg_pkg::SampleW'(0) - stg_pkg::SampleW'(mag_q)
                            : stg_pkg::SampleW'(mag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= stg_pkg::StepAccept;
      phase_q   <= '0;
      started_q <= 1'b0;
      reload_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      case (cw.op)
        stg_pkg::OP_ACCEPT: begin
          if (in_acc) begin
            reload_q <= s_axis_tuser_i || !started_q;
          end
        end
        stg_pkg::OP_PHASE: begin
          if (reload_q) begin
            phase_q <= stg_pkg::PhaseW'(start_q * phase_step_q);
          end
          started_q <= 1'b1;
        end
        stg_pkg::OP_SCALE: phase_q <= phase_q + phase_step_q;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cw.op)
      stg_pkg::OP_ACCEPT: begin
        if (in_acc) begin
          start_q <= s_axis_tdata_i;
        end
      end
      stg_pkg::OP_LOOKUP: begin
        rom_q <= qtab[rom_addr];
        neg_q <= phase_q[31];
      end
      stg_pkg::OP_SCALE: mag_q <= prod[2*stg_pkg::AmpW-1 -: stg_pkg::AmpW];
      default: ;
    endcase
  end

  // output register
  logic emit;
  assign emit = out_free &&
                ((cw.op == stg_pkg::OP_EMIT0) || (cw.op == stg_pkg::OP_EMIT1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
      m_axis_tdata_o  <= '0;
      m_axis_tuser_o  <= 1'b0;
      m_axis_tlast_o  <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid_o <= 1'b1;
      m_axis_tdata_o  <= sample_val;
      m_axis_tuser_o  <= (cw.op == stg_pkg::OP_EMIT1);
      m_axis_tlast_o  <= (cw.op == stg_pkg::OP_EMIT1) || single_chan;
    end else if (m_axis_tready_i) begin
      m_axis_tvalid_o <= 1'b0;
    end
  end

  // checks
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < stg_pkg::step_t'(stg_pkg::ProgLen))
    else $error("sequencer step out of program");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag cleared without reset");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (step_q == stg_pkg::StepPhase))
    else $error("accepted tick did not enter phase step");

  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> m_axis_tlast_o)
    else $error("second channel sample without tlast");

endmodule
